[src/prat_pkg.sv]
// shared types and codes for the resource accounting table
// no dependencies
package prat_pkg;

	typedef enum logic [1:0] {
		OP_UPDATE = 2'd0,
		OP_QUERY  = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_SET    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_BAD_ID  = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	// per-slot payload held in the data memory
	typedef struct packed {
		logic [63:0] start;
		logic [23:0] qp;
		logic [23:0] mr;
		logic [47:0] mem;
	} slot_data_t;

endpackage

[src/process_resource_accounting_table_top.sv]
// resource accounting table: owner scan, slot memories, global totals
// depends on prat_pkg and prat_ram
//
// Per-owner usage table with three wrapping global totals and a change counter.
// One transaction is taken at a time: in_ready is high only when the sequencer is
// idle, so a write-back returns to idle before the next accept. Update and query
// scan the owner memory one slot per cycle through its single read port, each
// compare in the cycle after its read. An update that misses scans every slot,
// fetches the entry, moves the three totals and writes back; one that finds the
// id stops the scan at that slot, and one on a full table ends after the scan.
// A query fetches the entry only on a hit. Clear fetches the entry, moves the
// totals and writes back, but stops after the fetch on an empty slot and at once
// when slot_sel is beyond the table; set, and an update or query with owner id
// zero, go straight to the result. Update and clear move the totals through one
// shared 48-bit add-subtract unit, one total per cycle. After reset a clearing
// pass over every slot empties the owner memory before the first transaction is
// accepted. A finished result sits in the output register; the next transaction
// may be accepted and worked on while it waits, and only its final write-back
// stalls until the previous result has been taken.
module process_resource_accounting_table_top #(
	parameter int SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [21:0] owner_id,
	input  logic [63:0] start_stamp,
	input  logic [5:0]  slot_sel,
	input  logic [23:0] qp_value,
	input  logic [23:0] mr_value,
	input  logic [47:0] mem_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic        found,
	output logic [5:0]  slot_used,
	output logic [23:0] entry_qp,
	output logic [23:0] entry_mr,
	output logic [47:0] entry_mem,
	output logic [23:0] total_qp,
	output logic [23:0] total_mr,
	output logic [47:0] total_mem,
	output logic [31:0] change_count
);

	import prat_pkg::*;

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);
	localparam int DW = $bits(slot_data_t);

	// sequencer states
	typedef enum logic [6:0] {
		S_CLR  = 7'b0000001,
		S_IDLE = 7'b0000010,
		S_SCAN = 7'b0000100,
		S_DRD  = 7'b0001000,
		S_DCAP = 7'b0010000,
		S_ACC  = 7'b0100000,
		S_FIN  = 7'b1000000
	} state_t;

	// which total the shared unit works on
	typedef enum logic [1:0] {
		F_QP  = 2'd0,
		F_MR  = 2'd1,
		F_MEM = 2'd2
	} fld_t;

	state_t state_q;
	fld_t   fld_q;

	// captured transaction
	op_t         op_q;
	logic [21:0] id_q;
	logic [63:0] stamp_q;
	logic [5:0]  sel_q;
	logic [23:0] qv_q;
	logic [23:0] mv_q;
	logic [47:0] bv_q;

	// scan bookkeeping
	logic [AW-1:0] clr_q;
	logic [AW-1:0] ia_q;
	logic          idone_q;
	logic [AW-1:0] ca_q;
	logic          cv_q;
	logic          hit_q;
	logic          emp_q;
	logic [AW-1:0] eslot_q;
	logic [AW-1:0] slot_q;
	status_t       st_q;

	// old entry contents and the stamp to be stored
	logic [23:0] old_qp_q;
	logic [23:0] old_mr_q;
	logic [47:0] old_mem_q;
	logic [63:0] new_start_q;

	// totals and change counter
	logic [23:0] sum_qp_q;
	logic [23:0] sum_mr_q;
	logic [47:0] sum_mem_q;
	logic [31:0] ver_q;

	// output register
	logic        out_valid_q;
	status_t     res_status_q;
	logic        res_found_q;
	logic [5:0]  res_used_q;
	logic [23:0] res_qp_q;
	logic [23:0] res_mr_q;
	logic [47:0] res_mem_q;
	logic [23:0] res_tqp_q;
	logic [23:0] res_tmr_q;
	logic [47:0] res_tmem_q;

	// memory ports
	logic          own_we;
	logic [AW-1:0] own_waddr;
	logic [21:0]   own_wdata;
	logic [AW-1:0] own_raddr;
	logic [21:0]   own_rdata;
	logic          dat_we;
	logic [AW-1:0] dat_waddr;
	slot_data_t    dat_wdata;
	logic [DW-1:0] dat_rdata_raw;
	slot_data_t    dat_rdata;

	// shared add-subtract unit: a + b - c
	logic [47:0] alu_a;
	logic [47:0] alu_b;
	logic [47:0] alu_c;
	logic [47:0] alu_y;

	logic          in_fire;
	logic          fin_go;
	logic [AW+5:0] sel_wide;
	logic [AW-1:0] sel_addr;
	logic [AW+5:0] slot_wide;
	logic [AW+5:0] used_wide;
	logic          emp_now;
	logic [AW-1:0] eslot_now;
	logic          reuse;
	logic          changes;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	// the write-back waits for the output register to be free
	assign fin_go   = (state_q == S_FIN) && (!out_valid_q || out_ready);

	assign sel_wide   = {{AW{1'b0}}, slot_sel};
	assign sel_addr   = sel_wide[AW-1:0];
	assign slot_wide  = {6'd0, slot_q};

	// first empty slot, counting the slot compared in this cycle
	assign emp_now   = emp_q || (cv_q && (own_rdata == 22'd0));
	assign eslot_now = emp_q ? eslot_q : ca_q;

	assign dat_rdata = slot_data_t'(dat_rdata_raw);

	// reused id: both stamps known and different
	assign reuse = hit_q && (stamp_q != 64'd0) && (dat_rdata.start != 64'd0)
		&& (stamp_q != dat_rdata.start);

	assign changes = (st_q == ST_OK) && (op_q != OP_QUERY);

	// owner memory ports
	always_comb begin
		own_we    = 1'b0;
		own_waddr = slot_q;
		own_wdata = 22'd0;
		if (state_q == S_CLR) begin
			own_we    = 1'b1;
			own_waddr = clr_q;
		end else if (fin_go && (st_q == ST_OK)) begin
			own_we    = (op_q == OP_UPDATE) || (op_q == OP_CLEAR);
			own_wdata = (op_q == OP_UPDATE) ? id_q : 22'd0;
		end
	end

	assign own_raddr = (state_q == S_SCAN) ? ia_q : slot_q;

	// data memory ports
	always_comb begin
		dat_we    = fin_go && (st_q == ST_OK)
			&& ((op_q == OP_UPDATE) || (op_q == OP_CLEAR));
		dat_waddr = slot_q;
		dat_wdata = '0;
		if (op_q == OP_UPDATE) begin
			dat_wdata.start = new_start_q;
			dat_wdata.qp    = qv_q;
			dat_wdata.mr    = mv_q;
			dat_wdata.mem   = bv_q;
		end
	end

	prat_ram #(
		.WIDTH(22),
		.DEPTH(SLOTS)
	) u_owner_ram (
		.clk  (clk),
		.we   (own_we),
		.waddr(own_waddr),
		.wdata(own_wdata),
		.raddr(own_raddr),
		.rdata(own_rdata)
	);

	prat_ram #(
		.WIDTH(DW),
		.DEPTH(SLOTS)
	) u_data_ram (
		.clk  (clk),
		.we   (dat_we),
		.waddr(dat_waddr),
		.wdata(DW'(dat_wdata)),
		.raddr(slot_q),
		.rdata(dat_rdata_raw)
	);

	// operand selection for the shared unit; clear adds nothing back
	always_comb begin
		alu_a = 48'd0;
		alu_b = 48'd0;
		alu_c = 48'd0;
		unique case (fld_q)
			F_QP: begin
				alu_a = 48'(sum_qp_q);
				alu_b = (op_q == OP_UPDATE) ? 48'(qv_q) : 48'd0;
				alu_c = 48'(old_qp_q);
			end
			F_MR: begin
				alu_a = 48'(sum_mr_q);
				alu_b = (op_q == OP_UPDATE) ? 48'(mv_q) : 48'd0;
				alu_c = 48'(old_mr_q);
			end
			F_MEM: begin
				alu_a = sum_mem_q;
				alu_b = (op_q == OP_UPDATE) ? bv_q : 48'd0;
				alu_c = old_mem_q;
			end
			default: begin
				alu_a = 48'd0;
			end
		endcase
	end

	assign alu_y = alu_a + alu_b - alu_c;

	// payload capture, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q    <= op_t'(operation);
			id_q    <= owner_id;
			stamp_q <= start_stamp;
			sel_q   <= slot_sel;
			qv_q    <= qp_value;
			mv_q    <= mr_value;
			bv_q    <= mem_value;
		end
		if (state_q == S_DCAP) begin
			old_qp_q  <= (hit_q || (op_q == OP_CLEAR)) ? dat_rdata.qp : 24'd0;
			old_mr_q  <= (hit_q || (op_q == OP_CLEAR)) ? dat_rdata.mr : 24'd0;
			old_mem_q <= (hit_q || (op_q == OP_CLEAR)) ? dat_rdata.mem : 48'd0;
			new_start_q <= (!hit_q || reuse) ? stamp_q : dat_rdata.start;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			fld_q       <= F_QP;
			clr_q       <= '0;
			ia_q        <= '0;
			idone_q     <= 1'b0;
			ca_q        <= '0;
			cv_q        <= 1'b0;
			hit_q       <= 1'b0;
			emp_q       <= 1'b0;
			eslot_q     <= '0;
			slot_q      <= '0;
			st_q        <= ST_OK;
			sum_qp_q    <= 24'd0;
			sum_mr_q    <= 24'd0;
			sum_mem_q   <= 48'd0;
			ver_q       <= 32'd1;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_fire) begin
						st_q    <= ST_OK;
						hit_q   <= 1'b0;
						emp_q   <= 1'b0;
						ia_q    <= '0;
						idone_q <= 1'b0;
						cv_q    <= 1'b0;
						slot_q  <= sel_addr;
						unique case (op_t'(operation))
							OP_UPDATE, OP_QUERY: begin
								if (owner_id == 22'd0) begin
									st_q    <= ST_BAD_ID;
									state_q <= S_FIN;
								end else begin
									state_q <= S_SCAN;
								end
							end
							OP_CLEAR: begin
								if (32'(slot_sel) >= 32'(SLOTS)) begin
									st_q    <= ST_EMPTY;
									state_q <= S_FIN;
								end else begin
									state_q <= S_DRD;
								end
							end
							OP_SET: begin
								state_q <= S_FIN;
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_SCAN: begin
					// issue one owner read per cycle
					if (!idone_q) begin
						ca_q <= ia_q;
						cv_q <= 1'b1;
						if (ia_q == LAST) begin
							idone_q <= 1'b1;
						end else begin
							ia_q <= ia_q + 1'b1;
						end
					end else begin
						cv_q <= 1'b0;
					end
					// compare the slot read in the previous cycle
					if (cv_q) begin
						if (own_rdata == id_q) begin
							hit_q   <= 1'b1;
							slot_q  <= ca_q;
							state_q <= S_DRD;
						end else begin
							emp_q   <= emp_now;
							eslot_q <= eslot_now;
							if (ca_q == LAST) begin
								if (op_q == OP_QUERY) begin
									state_q <= S_FIN;
								end else if (emp_now) begin
									slot_q  <= eslot_now;
									state_q <= S_DRD;
								end else begin
									st_q    <= ST_FULL;
									state_q <= S_FIN;
								end
							end
						end
					end
				end
				S_DRD: begin
					state_q <= S_DCAP;
				end
				S_DCAP: begin
					fld_q <= F_QP;
					if (op_q == OP_QUERY) begin
						state_q <= S_FIN;
					end else if ((op_q == OP_CLEAR) && (own_rdata == 22'd0)) begin
						st_q    <= ST_EMPTY;
						state_q <= S_FIN;
					end else begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					unique case (fld_q)
						F_QP: begin
							sum_qp_q <= alu_y[23:0];
							fld_q    <= F_MR;
						end
						F_MR: begin
							sum_mr_q <= alu_y[23:0];
							fld_q    <= F_MEM;
						end
						F_MEM: begin
							sum_mem_q <= alu_y;
							state_q   <= S_FIN;
						end
						default: begin
							fld_q <= F_QP;
						end
					endcase
				end
				S_FIN: begin
					if (fin_go) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (changes) begin
							ver_q <= ver_q + 32'd1;
						end
						if ((op_q == OP_SET) && (st_q == ST_OK)) begin
							sum_qp_q  <= qv_q;
							sum_mr_q  <= mv_q;
							sum_mem_q <= bv_q;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result fields, loaded when the write-back goes ahead
	always_ff @(posedge clk) begin
		if (fin_go) begin
			res_status_q <= st_q;
			res_found_q  <= 1'b0;
			res_used_q   <= 6'd0;
			res_qp_q     <= 24'd0;
			res_mr_q     <= 24'd0;
			res_mem_q    <= 48'd0;
			// totals held with the result so that the next transaction cannot move them
			if ((op_q == OP_SET) && (st_q == ST_OK)) begin
				res_tqp_q  <= qv_q;
				res_tmr_q  <= mv_q;
				res_tmem_q <= bv_q;
			end else begin
				res_tqp_q  <= sum_qp_q;
				res_tmr_q  <= sum_mr_q;
				res_tmem_q <= sum_mem_q;
			end
			if (op_q == OP_CLEAR) begin
				res_used_q <= sel_q;
			end
			if (st_q == ST_OK) begin
				unique case (op_q)
					OP_UPDATE: begin
						res_found_q <= hit_q;
						res_used_q  <= used_wide[5:0];
						res_qp_q    <= qv_q;
						res_mr_q    <= mv_q;
						res_mem_q   <= bv_q;
					end
					OP_QUERY: begin
						if (hit_q) begin
							res_found_q <= 1'b1;
							res_used_q  <= used_wide[5:0];
							res_qp_q    <= dat_rdata.qp;
							res_mr_q    <= dat_rdata.mr;
							res_mem_q   <= dat_rdata.mem;
						end
					end
					OP_CLEAR: begin
						res_qp_q  <= old_qp_q;
						res_mr_q  <= old_mr_q;
						res_mem_q <= old_mem_q;
					end
					OP_SET: begin
						res_found_q <= 1'b0;
					end
					default: begin
						res_found_q <= 1'b0;
					end
				endcase
			end
		end
	end

	assign used_wide = slot_wide;

	// totals come from the output register; the counter only moves at a write-back,
	// which waits for the output register, so it can be shown directly
	assign out_valid    = out_valid_q;
	assign status       = res_status_q;
	assign found        = res_found_q;
	assign slot_used    = res_used_q;
	assign entry_qp     = res_qp_q;
	assign entry_mr     = res_mr_q;
	assign entry_mem    = res_mem_q;
	assign total_qp     = res_tqp_q;
	assign total_mr     = res_tmr_q;
	assign total_mem    = res_tmem_q;
	assign change_count = ver_q;

endmodule

[src/prat_ram.sv]
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module prat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// self-checking testbench for the resource accounting table: directed table then random episodes
// depends on prat_pkg and process_resource_accounting_table_top (with prat_ram below it)
module tb;
	import prat_pkg::*;

	localparam int SLOTS = 64;
	localparam int DIR_ROWS = 24;
	localparam int N_RANDOM = 1076;
	localparam logic [21:0] MAX_ID = 22'h3FFFFF;
	localparam logic [23:0] MAX24 = 24'hFFFFFF;
	localparam logic [47:0] MAX48 = 48'hFFFFFFFFFFFF;
	localparam logic [63:0] ALL_ONES64 = 64'hFFFFFFFFFFFFFFFF;

	// one input transaction, as driven onto the ports
	typedef struct packed {
		op_t         op;
		logic [21:0] id;
		logic [63:0] stamp;
		logic [5:0]  sel;
		logic [23:0] qp;
		logic [23:0] mr;
		logic [47:0] mem;
	} txn_t;

	// one result transaction, as seen on the ports
	typedef struct packed {
		status_t     st;
		logic        fnd;
		logic [5:0]  slot;
		logic [23:0] eqp;
		logic [23:0] emr;
		logic [47:0] emem;
		logic [23:0] tqp;
		logic [23:0] tmr;
		logic [47:0] tmem;
		logic [31:0] ver;
	} acct_res_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  operation;
	logic [21:0] owner_id;
	logic [63:0] start_stamp;
	logic [5:0]  slot_sel;
	logic [23:0] qp_value;
	logic [23:0] mr_value;
	logic [47:0] mem_value;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic        found;
	logic [5:0]  slot_used;
	logic [23:0] entry_qp;
	logic [23:0] entry_mr;
	logic [47:0] entry_mem;
	logic [23:0] total_qp;
	logic [23:0] total_mr;
	logic [47:0] total_mem;
	logic [31:0] change_count;

	process_resource_accounting_table_top #(.SLOTS(SLOTS)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.owner_id     (owner_id),
		.start_stamp  (start_stamp),
		.slot_sel     (slot_sel),
		.qp_value     (qp_value),
		.mr_value     (mr_value),
		.mem_value    (mem_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.found        (found),
		.slot_used    (slot_used),
		.entry_qp     (entry_qp),
		.entry_mr     (entry_mr),
		.entry_mem    (entry_mem),
		.total_qp     (total_qp),
		.total_mr     (total_mr),
		.total_mem    (total_mem),
		.change_count (change_count)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mirror of the accounting state, moved on every accepted transaction
	logic [21:0] own_tab   [SLOTS];
	logic [63:0] stamp_tab [SLOTS];
	logic [23:0] qp_tab    [SLOTS];
	logic [23:0] mr_tab    [SLOTS];
	logic [47:0] mem_tab   [SLOTS];
	logic [23:0] tally_qp;
	logic [23:0] tally_mr;
	logic [47:0] tally_mem;
	logic [31:0] version;

	// results still owed by the block, oldest first
	acct_res_t pending_results[$];

	int  errors = 0;
	int  n_sent = 0;
	int  n_checked = 0;
	int  n_full = 0;
	int  n_reuse = 0;
	int  n_hits = 0;
	int  burst_left = 0;
	bit  calm = 1'b0;
	int  rdy_left = 0;
	bit  rdy_level = 1'b1;

	// directed stimulus table; rows with dir_typed set carry a hand-written result
	txn_t      dir_txn   [DIR_ROWS];
	bit        dir_typed [DIR_ROWS];
	acct_res_t dir_want  [DIR_ROWS];

	function automatic txn_t txn(op_t op, logic [21:0] id, logic [63:0] stamp,
			logic [5:0] sel, logic [23:0] qp, logic [23:0] mr, logic [47:0] mem);
		txn_t t;
		t.op = op;
		t.id = id;
		t.stamp = stamp;
		t.sel = sel;
		t.qp = qp;
		t.mr = mr;
		t.mem = mem;
		return t;
	endfunction

	function automatic acct_res_t want(status_t st, logic fnd, logic [5:0] slot,
			logic [23:0] eqp, logic [23:0] emr, logic [47:0] emem,
			logic [23:0] tqp, logic [23:0] tmr, logic [47:0] tmem, logic [31:0] ver);
		acct_res_t r;
		r.st = st;
		r.fnd = fnd;
		r.slot = slot;
		r.eqp = eqp;
		r.emr = emr;
		r.emem = emem;
		r.tqp = tqp;
		r.tmr = tmr;
		r.tmem = tmem;
		r.ver = ver;
		return r;
	endfunction

	// take a slot's usage out of the totals and zero it
	function automatic void drop_counts(int s);
		tally_qp = tally_qp - qp_tab[s];
		tally_mr = tally_mr - mr_tab[s];
		tally_mem = tally_mem - mem_tab[s];
		qp_tab[s] = '0;
		mr_tab[s] = '0;
		mem_tab[s] = '0;
	endfunction

	// works out the result of one transaction and moves the mirror state on
	function automatic acct_res_t account_txn(input txn_t t);
		acct_res_t r;
		int hit_at;
		int free_at;
		int s;
		r = '0;
		hit_at = -1;
		free_at = -1;
		s = 0;
		case (t.op)
			OP_UPDATE, OP_QUERY: begin
				// owner scan: first match wins, first empty slot remembered before it
				for (int i = 0; i < SLOTS; i++) begin
					if (hit_at < 0 && own_tab[i] == t.id)
						hit_at = i;
					else if (hit_at < 0 && free_at < 0 && own_tab[i] == '0)
						free_at = i;
				end
				if (t.id == '0) begin
					r.st = ST_BAD_ID;
				end else if (t.op == OP_QUERY) begin
					if (hit_at >= 0) begin
						r.fnd = 1'b1;
						r.slot = 6'(hit_at);
						r.eqp = qp_tab[hit_at];
						r.emr = mr_tab[hit_at];
						r.emem = mem_tab[hit_at];
						n_hits++;
					end
				end else if (hit_at < 0 && free_at < 0) begin
					r.st = ST_FULL;
					n_full++;
				end else begin
					if (hit_at >= 0) begin
						s = hit_at;
						r.fnd = 1'b1;
						n_hits++;
						// reused id: both stamps known and different
						if (t.stamp != '0 && stamp_tab[s] != '0 && t.stamp != stamp_tab[s]) begin
							drop_counts(s);
							stamp_tab[s] = t.stamp;
							n_reuse++;
						end
					end else begin
						s = free_at;
						own_tab[s] = t.id;
						stamp_tab[s] = t.stamp;
					end
					tally_qp = tally_qp + t.qp - qp_tab[s];
					tally_mr = tally_mr + t.mr - mr_tab[s];
					tally_mem = tally_mem + t.mem - mem_tab[s];
					qp_tab[s] = t.qp;
					mr_tab[s] = t.mr;
					mem_tab[s] = t.mem;
					version = version + 32'd1;
					r.slot = 6'(s);
					r.eqp = t.qp;
					r.emr = t.mr;
					r.emem = t.mem;
				end
			end
			OP_CLEAR: begin
				r.slot = t.sel;
				if (own_tab[t.sel] == '0) begin
					r.st = ST_EMPTY;
				end else begin
					r.eqp = qp_tab[t.sel];
					r.emr = mr_tab[t.sel];
					r.emem = mem_tab[t.sel];
					drop_counts(t.sel);
					own_tab[t.sel] = '0;
					stamp_tab[t.sel] = '0;
					version = version + 32'd1;
				end
			end
			default: begin
				tally_qp = t.qp;
				tally_mr = t.mr;
				tally_mem = t.mem;
				version = version + 32'd1;
			end
		endcase
		r.tqp = tally_qp;
		r.tmr = tally_mr;
		r.tmem = tally_mem;
		r.ver = version;
		return r;
	endfunction

	// an occupied slot picked at random, or any slot when the table is empty
	function automatic int live_slot();
		int base;
		int pick;
		int s;
		bit got;
		base = $urandom_range(0, SLOTS - 1);
		pick = base;
		got = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			s = (base + i) % SLOTS;
			if (!got && own_tab[s] != '0) begin
				pick = s;
				got = 1'b1;
			end
		end
		return pick;
	endfunction

	// nonzero owner id not held by any slot
	function automatic logic [21:0] fresh_id();
		logic [21:0] id;
		bit clash;
		id = '0;
		clash = 1'b1;
		while (clash) begin
			id = 22'($urandom_range(1, 32'h3FFFFF));
			clash = 1'b0;
			foreach (own_tab[i])
				if (own_tab[i] == id)
					clash = 1'b1;
		end
		return id;
	endfunction

	// small stamp values make reuse of a live id likely
	function automatic logic [63:0] pick_stamp();
		case ($urandom_range(0, 7))
			0, 1: return '0;
			2, 3, 4: return 64'($urandom_range(1, 3));
			5: return ALL_ONES64;
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	function automatic logic [23:0] pick_count();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return MAX24;
			2: return 24'($urandom_range(1, 15));
			default: return 24'($urandom());
		endcase
	endfunction

	function automatic logic [47:0] pick_bytes();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return MAX48;
			2: return 48'($urandom_range(1, 4095));
			default: return 48'({$urandom(), $urandom()});
		endcase
	endfunction

	// random transaction weighted towards owners already in the table
	function automatic txn_t mixed_txn();
		txn_t t;
		int k;
		k = $urandom_range(0, 99);
		if (k < 42)
			t.op = OP_UPDATE;
		else if (k < 64)
			t.op = OP_QUERY;
		else if (k < 90)
			t.op = OP_CLEAR;
		else
			t.op = OP_SET;
		k = $urandom_range(0, 99);
		if (k < 4)
			t.id = '0;
		else if (k < 62)
			t.id = own_tab[live_slot()];
		else if (k < 90)
			t.id = 22'($urandom_range(1, 80));
		else
			t.id = 22'($urandom());
		t.stamp = pick_stamp();
		if (t.op == OP_CLEAR && $urandom_range(0, 3) != 0)
			t.sel = 6'(live_slot());
		else
			t.sel = 6'($urandom_range(0, SLOTS - 1));
		t.qp = pick_count();
		t.mr = pick_count();
		t.mem = pick_bytes();
		return t;
	endfunction

	// present one transaction and hold it until accepted; bursts with random gaps unless calm
	task automatic offer(input txn_t t, input bit typed, input acct_res_t hand);
		acct_res_t predicted;
		if (!calm && burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			burst_left = $urandom_range(1, 6);
		end
		if (burst_left > 0)
			burst_left--;
		in_valid <= 1'b1;
		operation <= t.op;
		owner_id <= t.id;
		start_stamp <= t.stamp;
		slot_sel <= t.sel;
		qp_value <= t.qp;
		mr_value <= t.mr;
		mem_value <= t.mem;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		// accepted at this edge
		predicted = account_txn(t);
		pending_results.push_back(typed ? hand : predicted);
		n_sent++;
	endtask

	// stop sending until every owed result has come back
	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// update with fresh owners until the table is full, press on past full, then clear down
	task automatic fill_table();
		txn_t t;
		int n_free;
		int extra;
		extra = 0;
		while (extra < 5) begin
			t = mixed_txn();
			t.op = OP_UPDATE;
			t.id = fresh_id();
			n_free = 0;
			foreach (own_tab[i])
				if (own_tab[i] == '0)
					n_free++;
			if (n_free == 0) begin
				extra++;
				// a known owner must still get through on a full table
				if (extra == 3)
					t.id = own_tab[live_slot()];
			end
			offer(t, 1'b0, '0);
		end
		repeat (40) begin
			t = mixed_txn();
			t.op = OP_CLEAR;
			t.sel = 6'(live_slot());
			offer(t, 1'b0, '0);
		end
	endtask

	task automatic check_field(input string what, input logic [63:0] exp_v,
			input logic [63:0] got_v);
		if (got_v !== exp_v) begin
			errors++;
			if (errors <= 100)
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_v, got_v);
		end
	endtask

	// result side: compare each accepted result with the oldest expectation, then pick
	// the next ready level; long high and low runs, always high during calm stretches
	always @(posedge clk) begin : result_check
		acct_res_t exp_r;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: result with no transaction outstanding, expected none, got status %0d",
						$time, status);
				end else begin
					exp_r = pending_results.pop_front();
					check_field("status", 64'(exp_r.st), 64'(status));
					check_field("found", 64'(exp_r.fnd), 64'(found));
					check_field("slot_used", 64'(exp_r.slot), 64'(slot_used));
					check_field("entry_qp", 64'(exp_r.eqp), 64'(entry_qp));
					check_field("entry_mr", 64'(exp_r.emr), 64'(entry_mr));
					check_field("entry_mem", 64'(exp_r.emem), 64'(entry_mem));
					check_field("total_qp", 64'(exp_r.tqp), 64'(total_qp));
					check_field("total_mr", 64'(exp_r.tmr), 64'(total_mr));
					check_field("total_mem", 64'(exp_r.tmem), 64'(total_mem));
					check_field("change_count", 64'(exp_r.ver), 64'(change_count));
					n_checked++;
				end
			end
			if (calm) begin
				out_ready <= 1'b1;
			end else begin
				if (rdy_left == 0) begin
					rdy_level = ($urandom_range(0, 3) != 0);
					rdy_left = rdy_level ? $urandom_range(1, 10) : $urandom_range(1, 15);
				end
				rdy_left--;
				out_ready <= rdy_level;
			end
		end
	end

	// stimulus
	initial begin : stimulus
		txn_t t;
		int kind;
		int fills;
		in_valid = 1'b0;
		operation = OP_UPDATE;
		owner_id = '0;
		start_stamp = '0;
		slot_sel = '0;
		qp_value = '0;
		mr_value = '0;
		mem_value = '0;
		arst_n = 1'b0;
		fills = 0;

		// mirror starts from the reset state: empty table, zero totals, version one
		foreach (own_tab[i]) begin
			own_tab[i] = '0;
			stamp_tab[i] = '0;
			qp_tab[i] = '0;
			mr_tab[i] = '0;
			mem_tab[i] = '0;
		end
		tally_qp = '0;
		tally_mr = '0;
		tally_mem = '0;
		version = 32'd1;

		// directed table
		foreach (dir_typed[i])
			dir_typed[i] = 1'b0;
		// miss on an empty table right after reset
		dir_txn[0] = txn(OP_QUERY, 22'd5, 64'd0, 6'd0, 24'd0, 24'd0, 48'd0);
		dir_want[0] = want(ST_OK, 1'b0, 6'd0, '0, '0, '0, '0, '0, '0, 32'd1);
		// owner id zero on update and query
		dir_txn[1] = txn(OP_UPDATE, 22'd0, 64'd7, 6'd9, 24'd5, 24'd6, 48'd7);
		dir_want[1] = want(ST_BAD_ID, 1'b0, 6'd0, '0, '0, '0, '0, '0, '0, 32'd1);
		dir_txn[2] = txn(OP_QUERY, 22'd0, 64'd0, 6'd0, 24'd0, 24'd0, 48'd0);
		dir_want[2] = want(ST_BAD_ID, 1'b0, 6'd0, '0, '0, '0, '0, '0, '0, 32'd1);
		// clear of an empty slot at both ends of the table
		dir_txn[3] = txn(OP_CLEAR, 22'd0, 64'd0, 6'd63, 24'd0, 24'd0, 48'd0);
		dir_want[3] = want(ST_EMPTY, 1'b0, 6'd63, '0, '0, '0, '0, '0, '0, 32'd1);
		dir_txn[4] = txn(OP_CLEAR, MAX_ID, ALL_ONES64, 6'd0, MAX24, MAX24, MAX48);
		dir_want[4] = want(ST_EMPTY, 1'b0, 6'd0, '0, '0, '0, '0, '0, '0, 32'd1);
		// totals to all ones, then an update wraps them past zero
		dir_txn[5] = txn(OP_SET, 22'd0, 64'd0, 6'd0, MAX24, MAX24, MAX48);
		dir_want[5] = want(ST_OK, 1'b0, 6'd0, '0, '0, '0, MAX24, MAX24, MAX48, 32'd2);
		dir_txn[6] = txn(OP_UPDATE, MAX_ID, ALL_ONES64, 6'd0, 24'd1, 24'd2, 48'd3);
		dir_want[6] = want(ST_OK, 1'b0, 6'd0, 24'd1, 24'd2, 48'd3, 24'd0, 24'd1, 48'd2, 32'd3);
		dir_txn[7] = txn(OP_SET, 22'd1, 64'd1, 6'd1, 24'd0, 24'd0, 48'd0);
		dir_want[7] = want(ST_OK, 1'b0, 6'd0, '0, '0, '0, '0, '0, '0, 32'd4);
		foreach (dir_typed[i])
			dir_typed[i] = (i < 8);
		// new owner with unknown stamp and largest counts
		dir_txn[8] = txn(OP_UPDATE, 22'd1, 64'd0, 6'd0, MAX24, MAX24, MAX48);
		// stored stamp unknown: no reuse even with a new stamp
		dir_txn[9] = txn(OP_UPDATE, 22'd1, 64'h8000000000000000, 6'd0, 24'h123456, 24'h654321,
			48'h0000DEADBEEF);
		// same stamp, then a different one (reused id), then an unknown one
		dir_txn[10] = txn(OP_UPDATE, MAX_ID, ALL_ONES64, 6'd0, 24'd10, 24'd11, 48'd12);
		dir_txn[11] = txn(OP_UPDATE, MAX_ID, 64'd1, 6'd0, 24'd20, 24'd21, 48'd22);
		dir_txn[12] = txn(OP_UPDATE, MAX_ID, 64'd0, 6'd0, 24'd30, 24'd31, 48'd32);
		dir_txn[13] = txn(OP_QUERY, 22'd1, 64'd0, 6'd0, 24'd0, 24'd0, 48'd0);
		dir_txn[14] = txn(OP_CLEAR, 22'd0, 64'd0, 6'd0, 24'd0, 24'd0, 48'd0);
		dir_txn[15] = txn(OP_QUERY, MAX_ID, 64'd0, 6'd0, 24'd0, 24'd0, 48'd0);
		// freed slot zero is the first empty one again
		dir_txn[16] = txn(OP_UPDATE, 22'd7, 64'd9, 6'd0, 24'd1, 24'd1, 48'd1);
		dir_txn[17] = txn(OP_UPDATE, 22'd2, 64'd5, 6'd0, 24'd2, 24'd2, 48'd2);
		dir_txn[18] = txn(OP_CLEAR, 22'd0, 64'd0, 6'd1, 24'd0, 24'd0, 48'd0);
		dir_txn[19] = txn(OP_UPDATE, 22'd3, 64'd3, 6'd0, 24'h800000, 24'h800000, 48'h800000000000);
		// zero totals, then a clear drives them below zero
		dir_txn[20] = txn(OP_SET, 22'd0, 64'd0, 6'd0, 24'd0, 24'd0, 48'd0);
		dir_txn[21] = txn(OP_CLEAR, 22'd0, 64'd0, 6'd2, 24'd0, 24'd0, 48'd0);
		dir_txn[22] = txn(OP_CLEAR, 22'd0, 64'd0, 6'd40, 24'd0, 24'd0, 48'd0);
		dir_txn[23] = txn(OP_SET, 22'h2AAAAA, 64'hAAAAAAAAAAAAAAAA, 6'h2A, 24'hAAAAAA, 24'h555555,
			48'hAAAAAAAAAAAA);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_ROWS; i++)
			offer(dir_txn[i], dir_typed[i], dir_want[i]);
		// hold off until the block has drained
		settle();

		// random episodes: mostly mixed traffic over live owners, at most twice a fill to full
		while (n_sent < DIR_ROWS + N_RANDOM) begin
			kind = $urandom_range(0, 9);
			if (kind == 0 && fills < 2) begin
				calm = 1'b0;
				fill_table();
				fills++;
			end else begin
				calm = ($urandom_range(0, 5) == 0);
				repeat ($urandom_range(20, 80)) begin
					t = mixed_txn();
					offer(t, 1'b0, '0);
				end
			end
			if ($urandom_range(0, 2) == 0)
				settle();
		end
		calm = 1'b0;
		settle();
		// room for any stray result after the last one owed
		repeat (SLOTS + 16) @(posedge clk);

		$display("covered %0d transactions (%0d from the table), %0d results checked", n_sent,
			DIR_ROWS, n_checked);
		$display("owner hits %0d, reused ids %0d, table-full rejections %0d", n_hits, n_reuse,
			n_full);
		if (errors == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin : watchdog
		#8000000;
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("tb NOT OK");
		$finish;
	end

endmodule

[files.f]
src/prat_pkg.sv
src/prat_ram.sv
src/process_resource_accounting_table_top.sv
tb/sv/tb.sv
